### rtl/twodo_pkg.sv
// Types, register indexes and constants shared by the three-wheel odometry design
package twodo_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_START_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_START_HDG = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DPC       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ITW       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROR       = 3'd5;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [23:0] DPC_RESET = 24'd75539;
  localparam logic [23:0] ITW_RESET = 24'd65536;
  localparam logic [23:0] ROR_RESET = 24'd65536;

  // 2^32 / (2 pi) and the CORDIC start value (1/K in Q30)
  localparam logic signed [35:0] INV_TWO_PI_Q32  = 36'sd683565276;
  localparam logic signed [35:0] CORDIC_GAIN_Q30 = 36'sd652032874;

  localparam int unsigned AtanDepth = 24;

  // arctangent of 2^-i in 1/2^32 turn
  localparam logic [31:0] ATAN_TURN [AtanDepth] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] rear_count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_fine;
    logic signed [31:0] y_fine;
    logic [15:0]        heading_angle;
    logic signed [15:0] x_cm;
    logic signed [15:0] y_cm;
    logic [8:0]         heading_deg;
  } out_item_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] lo;
    logic signed [71:0] hi;
    lo = -72'sd2147483648;
    hi = 72'sd2147483647;
    if (v < lo) begin
      return 32'sh8000_0000;
    end else if (v > hi) begin
      return 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v < -17'sd32768) begin
      return 16'sh8000;
    end else if (v > 17'sd32767) begin
      return 16'sh7fff;
    end
    return v[15:0];
  endfunction

endpackage

### rtl/three_wheel_odometry_top.sv
// Three-wheel tracking odometry: sequenced shared multiplier and CORDIC
//
//  channel | dir | handshake                 | payload
//  in      | in  | in_valid_i / in_ready_o   | twodo_pkg::in_item_t
//  out     | out | out_valid_o / out_ready_i | twodo_pkg::out_item_t
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// After its transfer a sample steps through the states from S_FWD to S_FIN,
// paced by the single 36x36 multiplier and the one-rotation-per-cycle CORDIC.
// A restart jumps to S_FIN. in_ready_o is high only while the sequencer idles.
// A result held in the output register stalls the sequencer at its last step.
// Reset clears the pose, previous counts and registers to their reset values.
module three_wheel_odometry_top #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned ANGLE_BITS  = 16,
  parameter int unsigned TRIG_STEPS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  twodo_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output twodo_pkg::out_item_t        out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [twodo_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i
);
  import twodo_pkg::*;

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned Up16  = (AB >= 16) ? AB - 16 : 0;
  localparam int unsigned Dn16  = (AB >= 16) ? 0 : 16 - AB;
  localparam int unsigned DthSh = 48 - AB;
  localparam int unsigned ItW   = $clog2(TRIG_STEPS);
  localparam int unsigned MW    = 36;
  localparam int unsigned PW    = 72;
  localparam logic [ItW-1:0] LastIt = ItW'(TRIG_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FWD, S_DIFF, S_REAR, S_RAD, S_LAT, S_DTH, S_DTHW,
    S_CORDIC, S_DX1, S_DX2, S_DY1, S_DY2, S_POS, S_FIN
  } state_e;

  state_e state_q;

  logic signed [31:0] start_x_q, start_y_q;
  logic [15:0]        start_hdg_q;
  logic [23:0]        dpc_q, itw_q;
  logic signed [23:0] ror_q;

  logic [CW-1:0]        prev_l_q, prev_r_q, prev_b_q;
  logic signed [31:0]   pos_x_q, pos_y_q;
  logic [AB-1:0]        hdg_q;

  logic signed [CW:0]   dsum_q, ddif_q;
  logic signed [CW-1:0] db_q;
  logic signed [31:0]   fwd_q, diff_q, rear_q, rad_q, lat_q;
  logic [AB-1:0]        dth_q;
  logic signed [35:0]   cx_q, cy_q;
  logic signed [32:0]   cz_q;
  logic                 flip_q;
  logic [ItW-1:0]       it_q;
  logic signed [PW-1:0] prod_q, acc_q;
  logic signed [39:0]   dx_q;

  logic                 out_valid_q;
  out_item_t            out_q;

  logic signed [MW-1:0] mul_a, mul_b;

  // deltas at the input transfer
  logic signed [CW-1:0] dl, dr, db;
  assign dl = in_data_i.left_count[CW-1:0] - prev_l_q;
  assign dr = in_data_i.right_count[CW-1:0] - prev_r_q;
  assign db = in_data_i.rear_count[CW-1:0] - prev_b_q;

  logic in_xfer, out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_FWD:  begin mul_a = MW'(dsum_q); mul_b = MW'(signed'({1'b0, dpc_q})); end
      S_DIFF: begin mul_a = MW'(ddif_q); mul_b = MW'(signed'({1'b0, dpc_q})); end
      S_REAR: begin mul_a = MW'(db_q);   mul_b = MW'(signed'({1'b0, dpc_q})); end
      S_RAD:  begin mul_a = MW'(diff_q); mul_b = MW'(signed'({1'b0, itw_q})); end
      S_LAT:  begin mul_a = MW'(diff_q); mul_b = MW'(ror_q); end
      S_DTH:  begin mul_a = MW'(rad_q);  mul_b = INV_TWO_PI_Q32; end
      S_DX1:  begin mul_a = MW'(fwd_q);  mul_b = cx_q; end
      S_DX2:  begin mul_a = MW'(lat_q);  mul_b = cy_q; end
      S_DY1:  begin mul_a = MW'(fwd_q);  mul_b = cy_q; end
      S_DY2:  begin mul_a = MW'(lat_q);  mul_b = cx_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // rounding of the registered product
  logic signed [PW-1:0] p_r5, p_r4, p_r16, p_dth, p_dx, p_dy;
  assign p_r5  = (prod_q + (PW'(1) <<< 4))  >>> 5;
  assign p_r4  = (prod_q + (PW'(1) <<< 3))  >>> 4;
  assign p_r16 = (prod_q + (PW'(1) <<< 15)) >>> 16;
  assign p_dth = (prod_q + (PW'(1) <<< (DthSh - 1))) >>> DthSh;
  assign p_dx  = (acc_q - prod_q + (PW'(1) <<< 29)) >>> 30;
  assign p_dy  = (acc_q + prod_q + (PW'(1) <<< 29)) >>> 30;

  logic signed [PW-1:0] lat_w;
  assign lat_w = PW'(rear_q) - p_r16;

  // CORDIC set-up and one rotation
  logic [AB-1:0]      mid;
  logic [31:0]        a32;
  logic signed [32:0] z0;
  assign mid = hdg_q + p_dth[AB:1];
  assign a32 = 32'(mid) << (32 - AB);
  assign z0  = 33'(signed'(a32));

  logic signed [35:0] sx, sy, nx, ny;
  logic signed [32:0] nz, atan_v;
  assign sx     = cx_q >>> it_q;
  assign sy     = cy_q >>> it_q;
  assign atan_v = 33'(ATAN_TURN[it_q]);
  always_comb begin
    if (!cz_q[32]) begin
      nx = cx_q - sy;
      ny = cy_q + sx;
      nz = cz_q - atan_v;
    end else begin
      nx = cx_q + sy;
      ny = cy_q - sx;
      nz = cz_q + atan_v;
    end
  end

  // result fields
  logic [AB-1:0]      start_hdg;
  logic [AB+15:0]     hdg_ext;
  logic [AB+8:0]      deg_w;
  assign hdg_ext   = ((AB + 16)'(start_hdg_q) << Up16) >> Dn16;
  assign start_hdg = hdg_ext[AB-1:0];
  assign deg_w     = (AB + 9)'(hdg_q) * (AB + 9)'(360) + (AB + 9)'(1 << (AB - 1));

  logic [AB+15:0] h16_w;
  assign h16_w = ((AB + 16)'(hdg_q) >> Up16) << Dn16;

  logic signed [32:0] xr, yr;
  assign xr = (33'(pos_x_q) + 33'sd32768) >>> 16;
  assign yr = (33'(pos_y_q) + 33'sd32768) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_hdg_q <= '0;
      dpc_q       <= DPC_RESET;
      itw_q       <= ITW_RESET;
      ror_q       <= ROR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_X:   start_x_q   <= cfg_data_i;
        REG_START_Y:   start_y_q   <= cfg_data_i;
        REG_START_HDG: start_hdg_q <= cfg_data_i[15:0];
        REG_DPC:       dpc_q       <= cfg_data_i[23:0];
        REG_ITW:       itw_q       <= cfg_data_i[23:0];
        REG_ROR:       ror_q       <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prev_b_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      hdg_q       <= '0;
      out_valid_q <= 1'b0;
      it_q        <= '0;
    end else begin
      // the last step reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            prev_l_q <= in_data_i.left_count[CW-1:0];
            prev_r_q <= in_data_i.right_count[CW-1:0];
            prev_b_q <= in_data_i.rear_count[CW-1:0];
            dsum_q   <= (CW + 1)'(dl) + (CW + 1)'(dr);
            ddif_q   <= (CW + 1)'(dr) - (CW + 1)'(dl);
            db_q     <= db;
            if (in_data_i.cmd == CMD_RESTART) begin
              pos_x_q <= start_x_q;
              pos_y_q <= start_y_q;
              hdg_q   <= start_hdg;
              state_q <= S_FIN;
            end else begin
              state_q <= S_FWD;
            end
          end
        end
        S_FWD:  state_q <= S_DIFF;
        S_DIFF: begin fwd_q  <= sat32(p_r5); state_q <= S_REAR; end
        S_REAR: begin diff_q <= sat32(p_r4); state_q <= S_RAD;  end
        S_RAD:  begin rear_q <= sat32(p_r4); state_q <= S_LAT;  end
        S_LAT:  begin rad_q  <= sat32(p_r16); state_q <= S_DTH; end
        S_DTH:  begin lat_q  <= sat32(lat_w); state_q <= S_DTHW; end
        S_DTHW: begin
          dth_q <= p_dth[AB-1:0];
          cx_q  <= CORDIC_GAIN_Q30;
          cy_q  <= '0;
          it_q  <= '0;
          // fold the angle into the right half-plane
          if (z0 > 33'sd1073741824) begin
            cz_q   <= z0 - 33'sd2147483648;
            flip_q <= 1'b1;
          end else if (z0 < -33'sd1073741824) begin
            cz_q   <= z0 + 33'sd2147483648;
            flip_q <= 1'b1;
          end else begin
            cz_q   <= z0;
            flip_q <= 1'b0;
          end
          state_q <= S_CORDIC;
        end
        S_CORDIC: begin
          cz_q <= nz;
          it_q <= it_q + 1'b1;
          if (it_q == LastIt) begin
            cx_q    <= flip_q ? -nx : nx;
            cy_q    <= flip_q ? -ny : ny;
            state_q <= S_DX1;
          end else begin
            cx_q <= nx;
            cy_q <= ny;
          end
        end
        S_DX1: state_q <= S_DX2;
        S_DX2: begin acc_q <= prod_q; state_q <= S_DY1; end
        S_DY1: begin dx_q <= p_dx[39:0]; state_q <= S_DY2; end
        S_DY2: begin acc_q <= prod_q; state_q <= S_POS; end
        S_POS: begin
          pos_x_q <= sat32(PW'(pos_x_q) + PW'(dx_q));
          pos_y_q <= sat32(PW'(pos_y_q) + p_dy);
          hdg_q   <= hdg_q + dth_q;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q         <= 1'b1;
            out_q.x_fine        <= pos_x_q;
            out_q.y_fine        <= pos_y_q;
            out_q.heading_angle <= h16_w[15:0];
            out_q.x_cm          <= sat16(xr[16:0]);
            out_q.y_cm          <= sat16(yr[16:0]);
            out_q.heading_deg   <= deg_w[AB+8:AB];
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORDIC |-> it_q <= LastIt)
    else $error("CORDIC step count out of range");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready after input transfer");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && out_free |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule
